// File: src/tick_priority_task_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the task scheduler
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TICK_PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`define TICK_PRIORITY_TASK_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define TPTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TPTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tpts_pkg.sv
// ----------------------------------------------------------------------------
// Task scheduler package
// Slot count, command and status codes, slot entry and control structs.
// ----------------------------------------------------------------------------
package tpts_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int IDX_W     = (SLOT_W > 3) ? SLOT_W : 3;

    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_DISPATCH = 3'd1;
    localparam logic [2:0] CMD_ADD      = 3'd2;
    localparam logic [2:0] CMD_REMOVE   = 3'd3;
    localparam logic [2:0] CMD_SUSPEND  = 3'd4;
    localparam logic [2:0] CMD_RESUME   = 3'd5;

    localparam logic [1:0] RSP_OK    = 2'd0;
    localparam logic [1:0] RSP_FULL  = 2'd1;
    localparam logic [1:0] RSP_EMPTY = 2'd2;
    localparam logic [1:0] RSP_NONE  = 2'd3;

    typedef struct packed {
        logic        live;
        logic        held;
        logic [15:0] countdown;
        logic [15:0] reload;
        logic [7:0]  rank;
        logic [7:0]  pending;
    } slot_entry_t;

    typedef struct packed {
        logic        shift_en;
        slot_entry_t tail_entry;
    } ring_ctl_t;

    typedef struct packed {
        logic        busy;
        logic [31:0] tick_count;
    } seq_stat_t;

endpackage

// File: src/tpts_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one scheduler command.
// ----------------------------------------------------------------------------
interface tpts_req_if;

    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [2:0]  slot_index;
    logic [15:0] start_delay;
    logic [15:0] task_period;
    logic [7:0]  task_priority;

    modport source (
        output valid, cmd, slot_index, start_delay, task_period, task_priority,
        input  ready
    );

    modport sink (
        input  valid, cmd, slot_index, start_delay, task_period, task_priority,
        output ready
    );

endinterface

// File: src/tpts_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one command result.
// ----------------------------------------------------------------------------
interface tpts_rsp_if;

    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [2:0]  chosen_slot;
    logic [31:0] tick_total;

    modport source (
        output valid, status, chosen_slot, tick_total,
        input  ready
    );

    modport sink (
        input  valid, status, chosen_slot, tick_total,
        output ready
    );

endinterface

// File: src/tpts_cell.sv
// ----------------------------------------------------------------------------
// Slot cell
// Holds one slot entry of the rotating ring; loads its neighbour on shift.
// ----------------------------------------------------------------------------
module tpts_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 shift_en,
    input  tpts_pkg::slot_entry_t d,
    output tpts_pkg::slot_entry_t q
);

    tpts_pkg::slot_entry_t entry_reg;
    tpts_pkg::slot_entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (shift_en)
        begin
            entry_next = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign q = entry_reg;

endmodule

// File: src/tpts_seq.sv
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Runs passes over the slot ring, edits the head entry and issues results.
// ----------------------------------------------------------------------------
module tpts_seq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    tpts_req_if.sink              req,
    tpts_rsp_if.source            rsp,
    input  tpts_pkg::slot_entry_t head_entry,
    output tpts_pkg::ring_ctl_t   ring_ctl,
    output tpts_pkg::seq_stat_t   seq_stat
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [tpts_pkg::SLOT_W-1:0] pos_reg, pos_next;
    logic [tpts_pkg::SLOT_W-1:0] best_reg, best_next;
    logic [7:0]                 best_rank_reg, best_rank_next;
    logic                       found_reg, found_next;
    logic                       enable_reg, enable_next;
    logic [31:0]                tick_reg, tick_next;

    logic [2:0]                 cmd_reg;
    logic [2:0]                 idx_reg;
    logic [15:0]                delay_reg;
    logic [15:0]                period_reg;
    logic [7:0]                 prio_reg;

    logic                       out_valid_reg, out_valid_next;
    logic [1:0]                 out_status_reg;
    logic [2:0]                 out_slot_reg;
    logic [31:0]                out_tick_reg;
    logic [1:0]                 fin_status;
    logic [2:0]                 fin_slot;

    tpts_pkg::slot_entry_t      tail;
    logic                       accept;
    logic                       shifting;
    logic                       last_pos;
    logic                       at_index;
    logic                       candidate;
    logic                       out_load;

    assign accept    = req.valid && req.ready;
    assign shifting  = (state_reg == S_SCAN) || (state_reg == S_APPLY);
    assign last_pos  = pos_reg == tpts_pkg::SLOT_W'(tpts_pkg::NUM_SLOTS - 1);
    assign at_index  = tpts_pkg::IDX_W'(pos_reg) == tpts_pkg::IDX_W'(idx_reg);
    assign candidate = head_entry.live && !head_entry.held && (head_entry.pending != 8'd0);
    assign out_load  = (state_reg == S_FIN) && (!out_valid_reg || rsp.ready);

    // head edit and scan record for the slot now at the front of the ring
    always_comb
    begin
        tail           = head_entry;
        found_next     = found_reg;
        best_next      = best_reg;
        best_rank_next = best_rank_reg;
        if (state_reg == S_SCAN)
        begin
            case (cmd_reg)
                tpts_pkg::CMD_TICK:
                begin
                    if (enable_reg && head_entry.live)
                    begin
                        if (head_entry.countdown == 16'd0)
                        begin
                            if (head_entry.pending != 8'hFF)
                            begin
                                tail.pending = head_entry.pending + 8'd1;
                            end
                            if (head_entry.reload != 16'd0)
                            begin
                                tail.countdown = head_entry.reload;
                            end
                        end
                        else
                        begin
                            tail.countdown = head_entry.countdown - 16'd1;
                        end
                    end
                end
                tpts_pkg::CMD_DISPATCH:
                begin
                    if (candidate && (!found_reg || (head_entry.rank > best_rank_reg)))
                    begin
                        found_next     = 1'b1;
                        best_next      = pos_reg;
                        best_rank_next = head_entry.rank;
                    end
                end
                tpts_pkg::CMD_ADD:
                begin
                    if (!found_reg && !head_entry.live)
                    begin
                        tail.live      = 1'b1;
                        tail.held      = 1'b0;
                        tail.countdown = delay_reg;
                        tail.reload    = period_reg;
                        tail.rank      = prio_reg;
                        tail.pending   = 8'd0;
                        found_next     = 1'b1;
                        best_next      = pos_reg;
                    end
                end
                tpts_pkg::CMD_REMOVE:
                begin
                    if (at_index && head_entry.live)
                    begin
                        tail       = '0;
                        found_next = 1'b1;
                    end
                end
                tpts_pkg::CMD_SUSPEND:
                begin
                    if (at_index && head_entry.live)
                    begin
                        tail.held  = 1'b1;
                        found_next = 1'b1;
                    end
                end
                tpts_pkg::CMD_RESUME:
                begin
                    if (at_index && head_entry.live)
                    begin
                        tail.held  = 1'b0;
                        found_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == S_APPLY)
        begin
            if (pos_reg == best_reg)
            begin
                tail.pending = head_entry.pending - 8'd1;
                // one-shot task: free the slot
                if (head_entry.reload == 16'd0)
                begin
                    tail = '0;
                end
            end
        end
        if (accept)
        begin
            found_next     = 1'b0;
            best_next      = '0;
            best_rank_next = 8'd0;
        end
    end

    // result of the finished command
    always_comb
    begin
        fin_status = tpts_pkg::RSP_OK;
        fin_slot   = 3'd0;
        case (cmd_reg)
            tpts_pkg::CMD_ADD:
            begin
                fin_status = found_reg ? tpts_pkg::RSP_OK : tpts_pkg::RSP_FULL;
                fin_slot   = found_reg ? 3'(best_reg) : 3'd0;
            end
            tpts_pkg::CMD_DISPATCH:
            begin
                fin_status = found_reg ? tpts_pkg::RSP_OK : tpts_pkg::RSP_NONE;
                fin_slot   = found_reg ? 3'(best_reg) : 3'd0;
            end
            tpts_pkg::CMD_REMOVE, tpts_pkg::CMD_SUSPEND, tpts_pkg::CMD_RESUME:
            begin
                fin_status = found_reg ? tpts_pkg::RSP_OK : tpts_pkg::RSP_EMPTY;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        tick_next      = tick_reg;
        enable_next    = enable_reg;
        out_valid_next = out_valid_reg;
        if (cfg_we)
        begin
            enable_next = cfg_wdata;
        end
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        if (shifting)
        begin
            pos_next = last_pos ? '0 : pos_reg + 1'b1;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                    if (req.cmd == tpts_pkg::CMD_TICK)
                    begin
                        tick_next = tick_reg + 32'd1;
                    end
                end
            end
            S_SCAN:
            begin
                if (last_pos)
                begin
                    state_next = ((cmd_reg == tpts_pkg::CMD_DISPATCH) && found_next)
                                 ? S_APPLY : S_FIN;
                end
            end
            S_APPLY:
            begin
                if (last_pos)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            best_reg      <= '0;
            best_rank_reg <= 8'd0;
            found_reg     <= 1'b0;
            enable_reg    <= 1'b0;
            tick_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            best_reg      <= best_next;
            best_rank_reg <= best_rank_next;
            found_reg     <= found_next;
            enable_reg    <= enable_next;
            tick_reg      <= tick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= req.cmd;
            idx_reg    <= req.slot_index;
            delay_reg  <= req.start_delay;
            period_reg <= req.task_period;
            prio_reg   <= req.task_priority;
        end
        if (out_load)
        begin
            out_status_reg <= fin_status;
            out_slot_reg   <= fin_slot;
            out_tick_reg   <= tick_reg;
        end
    end

    assign req.ready       = state_reg == S_IDLE;
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.chosen_slot = out_slot_reg;
    assign rsp.tick_total  = out_tick_reg;

    assign ring_ctl.shift_en   = shifting;
    assign ring_ctl.tail_entry = tail;
    assign seq_stat.busy       = state_reg != S_IDLE;
    assign seq_stat.tick_count = tick_reg;

endmodule

// File: src/tick_priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// Tick priority task scheduler
// Slot table for a tick-driven cooperative scheduler, held in a rotating ring.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command (tick, dispatch, add, remove, suspend, resume)
//   with its slot index, start delay, period and priority. rsp returns one
//   result per request: status, chosen slot and the tick count after it.
//   cfg_we/cfg_wdata write scheduler_enable; write it only while idle.
//   The slot table is a ring of NUM_SLOTS cells that rotates one place per
//   cycle during a pass; each pass brings every slot, lowest first, past the
//   head logic. A request takes one pass, then the sequencer posts the
//   result from S_FIN into the output register. A dispatch that finds a
//   task needs a second pass to update it. One request is in work at a
//   time; the next is taken once the result has posted.
//   A new request is taken while a finished result still waits in the
//   output register; if the receiver stalls, the next result holds in the
//   sequencer until the register frees.
//   Reset empties every slot, clears the tick count and disables the
//   scheduler; the block is ready to take a request as soon as reset is released.
// ----------------------------------------------------------------------------
`include "tick_priority_task_scheduler_defines.svh"

module tick_priority_task_scheduler (
    input  logic       clk,
    input  logic       rst_n,
    tpts_req_if.sink   req,
    tpts_rsp_if.source rsp,
    input  logic       cfg_we,
    input  logic       cfg_wdata
);

    tpts_pkg::slot_entry_t ring_q [tpts_pkg::NUM_SLOTS];
    tpts_pkg::ring_ctl_t   ring_ctl;
    tpts_pkg::seq_stat_t   seq_stat;

    genvar gi;
    generate
        for (gi = 0; gi < tpts_pkg::NUM_SLOTS; gi++)
        begin : g_cell
            if (gi == tpts_pkg::NUM_SLOTS - 1)
            begin : g_tail
                tpts_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (ring_ctl.shift_en),
                    .d        (ring_ctl.tail_entry),
                    .q        (ring_q[gi])
                );
            end
            else
            begin : g_body
                tpts_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (ring_ctl.shift_en),
                    .d        (ring_q[gi+1]),
                    .q        (ring_q[gi])
                );
            end
        end
    endgenerate

    tpts_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req        (req),
        .rsp        (rsp),
        .head_entry (ring_q[0]),
        .ring_ctl   (ring_ctl),
        .seq_stat   (seq_stat)
    );

    `TPTS_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready,
        "request accepted while a pass was starting")
    `TPTS_ASSERT_NOW(a_ring_still_when_idle, !seq_stat.busy, !ring_ctl.shift_en,
        "slot ring rotated outside a pass")
    `TPTS_ASSERT_NEXT(a_tick_only_on_tick,
        req.valid && req.ready && (req.cmd != tpts_pkg::CMD_TICK),
        $stable(seq_stat.tick_count),
        "tick count moved on a non-tick request")

endmodule

// File: dv/tb_tick_priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// Testbench for the tick priority task scheduler
// Requests go in through a bursty valid/ready driver and results come back
// through a monitor with its own stall pattern. Each accepted request is run
// through a cycle-free copy of the slot table and the predicted status, slot
// and tick count are checked in order against the results. The run covers
// directed corner cases, a pending-count saturation sequence and random
// phases with the scheduler both enabled and disabled.
// ----------------------------------------------------------------------------
module tb_tick_priority_task_scheduler;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_IDLE  = 24;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 180;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [2:0]  slot_index;
        logic [15:0] start_delay;
        logic [15:0] task_period;
        logic [7:0]  task_priority;
    } sched_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  chosen_slot;
        logic [31:0] tick_total;
    } sched_rsp_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    tpts_req_if req ();
    tpts_rsp_if rsp ();

    tick_priority_task_scheduler DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // shadow slot table
    bit          tbl_live     [tpts_pkg::NUM_SLOTS];
    bit          tbl_held     [tpts_pkg::NUM_SLOTS];
    logic [15:0] tbl_countdown[tpts_pkg::NUM_SLOTS];
    logic [15:0] tbl_reload   [tpts_pkg::NUM_SLOTS];
    logic [7:0]  tbl_rank     [tpts_pkg::NUM_SLOTS];
    logic [7:0]  tbl_pending  [tpts_pkg::NUM_SLOTS];
    logic [31:0] tbl_ticks;
    bit          tbl_enable;

    sched_req_t  cmd_queue[$];
    sched_rsp_t  result_queue[$];
    sched_req_t  in_flight;

    int          burst_left;
    int          gap_left;
    int          stall_left;
    int          hold_requests;
    int          hold_seen;
    int          hold_left;
    logic [31:0] cycle_count = '0;

    int          errors    = 0;
    int          n_checked = 0;
    int          n_full    = 0;
    int          n_empty   = 0;
    int          n_none    = 0;

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void clear_slot(input int s);
        tbl_live[s]      = 1'b0;
        tbl_held[s]      = 1'b0;
        tbl_countdown[s] = '0;
        tbl_reload[s]    = '0;
        tbl_rank[s]      = '0;
        tbl_pending[s]   = '0;
    endfunction

    function automatic sched_rsp_t sched_predict(input sched_req_t r);
        sched_rsp_t res;
        int         s;
        int         best;
        bit         found;
        bit         occupied;
        res.status      = tpts_pkg::RSP_OK;
        res.chosen_slot = '0;
        occupied = (int'(r.slot_index) < tpts_pkg::NUM_SLOTS) && tbl_live[r.slot_index];
        case (r.cmd)
            tpts_pkg::CMD_TICK:
            begin
                tbl_ticks = tbl_ticks + 32'd1;
                if (tbl_enable)
                begin
                    for (s = 0; s < tpts_pkg::NUM_SLOTS; s++)
                    begin
                        if (tbl_live[s])
                        begin
                            if (tbl_countdown[s] == 16'd0)
                            begin
                                // saturate the run count
                                if (tbl_pending[s] != 8'hFF)
                                    tbl_pending[s] = tbl_pending[s] + 8'd1;
                                if (tbl_reload[s] != 16'd0)
                                    tbl_countdown[s] = tbl_reload[s];
                            end
                            else
                            begin
                                tbl_countdown[s] = tbl_countdown[s] - 16'd1;
                            end
                        end
                    end
                end
            end
            tpts_pkg::CMD_DISPATCH:
            begin
                found = 1'b0;
                best  = 0;
                for (s = 0; s < tpts_pkg::NUM_SLOTS; s++)
                begin
                    if (tbl_live[s] && !tbl_held[s] && tbl_pending[s] != 8'd0)
                    begin
                        // strict compare keeps the lowest slot on a tie
                        if (!found || tbl_rank[s] > tbl_rank[best])
                        begin
                            best  = s;
                            found = 1'b1;
                        end
                    end
                end
                if (!found)
                begin
                    res.status = tpts_pkg::RSP_NONE;
                end
                else
                begin
                    res.chosen_slot   = best[2:0];
                    tbl_pending[best] = tbl_pending[best] - 8'd1;
                    if (tbl_reload[best] == 16'd0)
                        clear_slot(best);
                end
            end
            tpts_pkg::CMD_ADD:
            begin
                for (s = 0; s < tpts_pkg::NUM_SLOTS; s++)
                    if (!tbl_live[s])
                        break;
                if (s >= tpts_pkg::NUM_SLOTS)
                begin
                    res.status = tpts_pkg::RSP_FULL;
                end
                else
                begin
                    tbl_live[s]      = 1'b1;
                    tbl_held[s]      = 1'b0;
                    tbl_countdown[s] = r.start_delay;
                    tbl_reload[s]    = r.task_period;
                    tbl_rank[s]      = r.task_priority;
                    tbl_pending[s]   = 8'd0;
                    res.chosen_slot  = s[2:0];
                end
            end
            tpts_pkg::CMD_REMOVE:
            begin
                if (!occupied)
                    res.status = tpts_pkg::RSP_EMPTY;
                else
                    clear_slot(r.slot_index);
            end
            tpts_pkg::CMD_SUSPEND:
            begin
                if (!occupied)
                    res.status = tpts_pkg::RSP_EMPTY;
                else
                    tbl_held[r.slot_index] = 1'b1;
            end
            tpts_pkg::CMD_RESUME:
            begin
                if (!occupied)
                    res.status = tpts_pkg::RSP_EMPTY;
                else
                    tbl_held[r.slot_index] = 1'b0;
            end
            default:
            begin
            end
        endcase
        res.tick_total = tbl_ticks;
        return res;
    endfunction

    function automatic void push_req(input logic [2:0] c, input logic [2:0] idx,
                                     input logic [15:0] dly, input logic [15:0] per,
                                     input logic [7:0] pri);
        sched_req_t r;
        r.cmd           = c;
        r.slot_index    = idx;
        r.start_delay   = dly;
        r.task_period   = per;
        r.task_priority = pri;
        cmd_queue.push_back(r);
    endfunction

    function automatic sched_req_t random_req();
        sched_req_t r;
        int         w;
        w               = $urandom_range(0, 99);
        r.slot_index    = 3'($urandom_range(0, 7));
        r.start_delay   = 16'($urandom);
        r.task_period   = 16'($urandom);
        r.task_priority = 8'($urandom);
        if (w < 32)
            r.cmd = tpts_pkg::CMD_TICK;
        else if (w < 52)
            r.cmd = tpts_pkg::CMD_DISPATCH;
        else if (w < 72)
            r.cmd = tpts_pkg::CMD_ADD;
        else if (w < 82)
            r.cmd = tpts_pkg::CMD_REMOVE;
        else if (w < 89)
            r.cmd = tpts_pkg::CMD_SUSPEND;
        else if (w < 96)
            r.cmd = tpts_pkg::CMD_RESUME;
        else
            r.cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE_A : CMD_SPARE_B;
        if (r.cmd == tpts_pkg::CMD_ADD)
        begin
            // mostly short delays and periods so that runs come up often
            w = $urandom_range(0, 9);
            if (w < 7)
                r.start_delay = 16'($urandom_range(0, 6));
            else if (w < 9)
                r.start_delay = 16'($urandom_range(0, 40));
            w = $urandom_range(0, 19);
            if (w < 5)
                r.task_period = '0;
            else if (w < 16)
                r.task_period = 16'($urandom_range(1, 8));
            else if (w < 18)
                r.task_period = 16'($urandom_range(0, 60));
            if ($urandom_range(0, 1) == 0)
                r.task_priority = 8'($urandom_range(0, 3));
        end
        return r;
    endfunction

    task automatic wait_idle();
        @(negedge clk);
        while (cmd_queue.size() != 0 || req.valid || result_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_IDLE) @(negedge clk);
    endtask

    task automatic write_enable(input bit v);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        tbl_enable = v;
        @(negedge clk);
    endtask

    // request driver: bursts of random length, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin : request_driver
        sched_req_t nxt;
        bit         offer;
        if (!rst_n)
        begin
            req.valid         <= 1'b0;
            req.cmd           <= '0;
            req.slot_index    <= '0;
            req.start_delay   <= '0;
            req.task_period   <= '0;
            req.task_priority <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (req.valid && req.ready)
                result_queue.push_back(sched_predict(in_flight));
            if (!req.valid || req.ready)
            begin
                offer = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (cmd_queue.size() != 0)
                begin
                    nxt       = cmd_queue.pop_front();
                    in_flight = nxt;
                    offer     = 1'b1;
                    req.cmd           <= nxt.cmd;
                    req.slot_index    <= nxt.slot_index;
                    req.start_delay   <= nxt.start_delay;
                    req.task_period   <= nxt.task_period;
                    req.task_priority <= nxt.task_priority;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                req.valid <= offer;
            end
        end
    end

    // long receiver hold-off, started on request from the stimulus
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
        end
    end

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        sched_rsp_t got;
        sched_rsp_t want;
        bit         rdy_next;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.status      = rsp.status;
                got.chosen_slot = rsp.chosen_slot;
                got.tick_total  = rsp.tick_total;
                if (result_queue.size() == 0)
                begin
                    $display("%0t ERROR unexpected result: status %0d slot %0d ticks %0d",
                             $time, got.status, got.chosen_slot, got.tick_total);
                    errors++;
                end
                else
                begin
                    want = result_queue.pop_front();
                    n_checked++;
                    if (got.status !== want.status)
                    begin
                        $display("%0t ERROR status: expected %0d, actual %0d",
                                 $time, want.status, got.status);
                        errors++;
                    end
                    if (got.chosen_slot !== want.chosen_slot)
                    begin
                        $display("%0t ERROR chosen_slot: expected %0d, actual %0d",
                                 $time, want.chosen_slot, got.chosen_slot);
                        errors++;
                    end
                    if (got.tick_total !== want.tick_total)
                    begin
                        $display("%0t ERROR tick_total: expected %0d, actual %0d",
                                 $time, want.tick_total, got.tick_total);
                        errors++;
                    end
                    case (want.status)
                        tpts_pkg::RSP_FULL:  n_full++;
                        tpts_pkg::RSP_EMPTY: n_empty++;
                        tpts_pkg::RSP_NONE:  n_none++;
                        default:   ;
                    endcase
                end
            end
            // stall pattern follows bits 8:7 of the cycle counter
            if (hold_left > 0)
            begin
                rdy_next = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rdy_next = 1'b0;
            end
            else
            begin
                case (cycle_count[8:7])
                    2'd0: rdy_next = 1'b1;
                    2'd1:
                    begin
                        rdy_next = 1'b1;
                        if ($urandom_range(0, 3) == 0)
                            stall_left = $urandom_range(1, 8);
                    end
                    2'd2: rdy_next = 1'($urandom_range(0, 1));
                    default: rdy_next = cycle_count[0];
                endcase
            end
            rsp.ready <= rdy_next;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 32'd1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, result_queue.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stimulus
        int i;
        int p;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = 1'b0;
        hold_requests     = 0;
        for (i = 0; i < tpts_pkg::NUM_SLOTS; i++)
            clear_slot(i);
        tbl_ticks  = '0;
        tbl_enable = 1'b0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table, scheduler disabled
        push_req(tpts_pkg::CMD_DISPATCH, 3'd0, 16'd0, 16'd0, 8'd0);
        push_req(tpts_pkg::CMD_REMOVE,   3'd0, 16'd0, 16'd0, 8'd0);
        push_req(tpts_pkg::CMD_SUSPEND,  3'd7, 16'hFFFF, 16'hFFFF, 8'hFF);
        push_req(tpts_pkg::CMD_RESUME,   3'd3, 16'h5A5A, 16'hA5A5, 8'h3C);
        push_req(tpts_pkg::CMD_TICK,     3'd0, 16'd0, 16'd0, 8'd0);
        push_req(tpts_pkg::CMD_ADD,      3'd0, 16'd0, 16'd0, 8'hFF);
        push_req(tpts_pkg::CMD_ADD,      3'd0, 16'hFFFF, 16'hFFFF, 8'd0);
        push_req(tpts_pkg::CMD_TICK,     3'd0, 16'd0, 16'd0, 8'd0);
        push_req(tpts_pkg::CMD_DISPATCH, 3'd0, 16'd0, 16'd0, 8'd0);
        write_enable(1'b1);

        // held task is skipped, one-shot task leaves its slot on dispatch
        push_req(tpts_pkg::CMD_TICK,     3'd0, 16'd0, 16'd0, 8'd0);
        push_req(tpts_pkg::CMD_SUSPEND,  3'd0, 16'd0, 16'd0, 8'd0);
        push_req(tpts_pkg::CMD_DISPATCH, 3'd0, 16'd0, 16'd0, 8'd0);
        push_req(tpts_pkg::CMD_RESUME,   3'd0, 16'd0, 16'd0, 8'd0);
        push_req(tpts_pkg::CMD_DISPATCH, 3'd0, 16'd0, 16'd0, 8'd0);
        // fill the table with equal ranks, then overflow it
        for (i = 0; i < tpts_pkg::NUM_SLOTS; i++)
            push_req(tpts_pkg::CMD_ADD, 3'd0, 16'd0, 16'd1, 8'd5);
        push_req(tpts_pkg::CMD_TICK,     3'd0, 16'd0, 16'd0, 8'd0);
        push_req(tpts_pkg::CMD_DISPATCH, 3'd0, 16'd0, 16'd0, 8'd0);
        push_req(tpts_pkg::CMD_REMOVE,   3'd2, 16'd0, 16'd0, 8'd0);
        push_req(CMD_SPARE_A,            3'd5, 16'h1234, 16'h8001, 8'h81);
        push_req(CMD_SPARE_B,            3'd2, 16'hFFFF, 16'h0000, 8'h7E);
        push_req(tpts_pkg::CMD_DISPATCH, 3'd0, 16'd0, 16'd0, 8'd0);
        push_req(tpts_pkg::CMD_REMOVE,   3'd1, 16'd0, 16'd0, 8'd0);
        wait_idle();

        // drive one periodic task's run count into saturation, then drain it
        for (i = 0; i < tpts_pkg::NUM_SLOTS; i++)
            push_req(tpts_pkg::CMD_REMOVE, i[2:0], 16'd0, 16'd0, 8'd0);
        push_req(tpts_pkg::CMD_ADD, 3'd0, 16'd0, 16'd1, 8'd200);
        for (i = 0; i < 520; i++)
            push_req(tpts_pkg::CMD_TICK, 3'd0, 16'd0, 16'd0, 8'd0);
        for (i = 0; i < 256; i++)
            push_req(tpts_pkg::CMD_DISPATCH, 3'd0, 16'd0, 16'd0, 8'd0);
        wait_idle();

        for (p = 0; p < RAND_PHASES; p++)
        begin
            write_enable((p % 3) != 0);
            for (i = 0; i < PHASE_ITEMS; i++)
                cmd_queue.push_back(random_req());
            // stall the receiver long enough for the block to back up
            if (p == 1)
                hold_requests++;
        end
        write_enable(1'b1);
        wait_idle();

        $display("checked %0d results over %0d random phases and a saturation run",
                 n_checked, RAND_PHASES);
        $display("statuses seen: %0d table full, %0d slot empty, %0d nothing ready",
                 n_full, n_empty, n_none);
        if (errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("%0d mismatches", errors);
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/tpts_pkg.sv
src/tpts_req_if.sv
src/tpts_rsp_if.sv
src/tpts_cell.sv
src/tpts_seq.sv
src/tick_priority_task_scheduler.sv
dv/tb_tick_priority_task_scheduler.sv
